/* src/cpi_pkg.sv */
`default_nettype none

package cpi_pkg;

  // Data path widths
  localparam int DataW        = 32;
  localparam int CountW       = 5;
  localparam int SlotW        = 4;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 5;
  localparam int MaxPointsDef = 16;

  // Command codes on func
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPointCount = 1'b0,
    CfgLinearMode = 1'b1
  } cfg_reg_e;

  // How a mapped value was obtained
  typedef enum logic [2:0] {
    HowPass    = 3'd0,
    HowExact   = 3'd1,
    HowClampLo = 3'd2,
    HowClampHi = 3'd3,
    HowInterp  = 3'd4
  } how_e;

  // Request to the serial divider
  typedef struct packed {
    logic                 start;
    logic [2*DataW-1:0]   dividend;
    logic [DataW-1:0]     divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* src/cpi_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend's upper half
// must be below the divisor so that the quotient fits DataW bits.
module cpi_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cpi_pkg::div_req_t              req_i,
  output logic                                done_o,
  output logic [cpi_pkg::DataW-1:0]           quotient_o
);

  localparam int W  = cpi_pkg::DataW;
  localparam int NW = $clog2(W);

  logic          active_q;
  logic          done_q;
  logic [NW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  acc_q;
  logic [W-1:0]  divisor_q;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;

  // One trial subtraction
  always_comb begin
    trial = {rem_q, acc_q[W-1]};
    diff  = trial - {1'b0, divisor_q};
    ge    = trial >= {1'b0, divisor_q};
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + NW'(1);
        if (cnt_q == NW'(W - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.dividend[2*W-1:W];
      acc_q     <= req_i.dividend[W-1:0];
      divisor_q <= req_i.divisor;
    end else if (active_q) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      acc_q <= {acc_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

`default_nettype wire

/* src/curve_point_interpolator_top.sv */
`default_nettype none

// Piecewise-linear curve lookup. A point write (func 0) is taken while idle
// and busy stays low. A query (func 1) scans the n points in use one per
// cycle through the point memory's single registered read port, then
// decides; a curve with no points gives its result without a scan.
// Interpolation adds a difference step, one 32x32 multiply and the
// 32-step serial divider. The result is on mapped_value_o and how_found_o
// for exactly one cycle with strobe_o high and cannot be held off; a new
// start may be given in that same cycle.
module curve_point_interpolator_top #(
  parameter int MAX_POINTS = cpi_pkg::MaxPointsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               func_i,
  input  wire logic [cpi_pkg::SlotW-1:0]          point_slot_i,
  input  wire logic signed [cpi_pkg::DataW-1:0]   point_input_i,
  input  wire logic signed [cpi_pkg::DataW-1:0]   point_output_i,
  input  wire logic signed [cpi_pkg::DataW-1:0]   query_value_i,
  // result
  output logic                                    strobe_o,
  output logic signed [cpi_pkg::DataW-1:0]        mapped_value_o,
  output logic [2:0]                              how_found_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cpi_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [cpi_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int W  = cpi_pkg::DataW;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StPrep,
    StMul,
    StDivGo,
    StDivWait
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               idx_q;
  logic [CW-1:0]               n_q;
  logic                        match_q;
  logic                        seg_q;
  logic                        strobe_q;
  logic signed [W-1:0]         mapped_q;
  cpi_pkg::how_e               how_q;
  logic [cpi_pkg::CountW-1:0]  point_count_q;
  logic                        linear_q;

  // data path registers
  logic signed [W-1:0]         q_q;
  logic signed [W-1:0]         prev_in_q, prev_out_q;
  logic signed [W-1:0]         first_in_q, first_out_q;
  logic signed [W-1:0]         match_out_q;
  logic signed [W-1:0]         lin_q, lout_q, rin_q, rout_q;
  logic [W-1:0]                span_q, run_q, mag_q;
  logic                        neg_q;
  logic [2*W-1:0]              prod_q;

  // point memory: input in the upper half, output in the lower half
  logic [2*W-1:0]              mem_q [MAX_POINTS];
  logic [2*W-1:0]              rd_q;
  logic [AW-1:0]               rd_addr;

  logic                        accept;
  logic                        wr_en;
  logic [CW-1:0]               n_sat;
  logic signed [W-1:0]         rd_in, rd_out;
  logic                        hit_eq, seg_hit, last_pt;
  logic [W:0]                  rise;
  logic [W:0]                  rise_neg;
  cpi_pkg::div_req_t           div_req;
  logic                        div_done;
  logic [W-1:0]                quo;

  assign accept      = start && !busy;
  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  assign wr_en = accept && (func_i == cpi_pkg::FuncWrite)
                 && (int'(point_slot_i) < MAX_POINTS);

  // count in use, saturated to capacity
  assign n_sat = (int'(point_count_q) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                    : CW'(point_count_q);

  // next read address: one point ahead of the one being checked
  always_comb begin
    rd_addr = '0;
    if (state_q == StScan && (idx_q + CW'(1)) < n_q) begin
      rd_addr = AW'(idx_q + CW'(1));
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(point_slot_i)] <= {point_input_i, point_output_i};
    end
    rd_q <= mem_q[rd_addr];
  end

  // scan compares
  always_comb begin
    rd_in   = $signed(rd_q[2*W-1:W]);
    rd_out  = $signed(rd_q[W-1:0]);
    hit_eq  = (rd_in == q_q);
    seg_hit = (q_q >= prev_in_q) && (q_q <= rd_in);
    last_pt = (idx_q == n_q - CW'(1));
  end

  // segment differences
  always_comb begin
    rise     = {rout_q[W-1], rout_q} - {lout_q[W-1], lout_q};
    rise_neg = -rise;
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      idx_q         <= '0;
      n_q           <= '0;
      match_q       <= 1'b0;
      seg_q         <= 1'b0;
      strobe_q      <= 1'b0;
      mapped_q      <= '0;
      how_q         <= cpi_pkg::HowPass;
      point_count_q <= '0;
      linear_q      <= 1'b0;
    end else begin
      strobe_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cpi_pkg::CfgPointCount: point_count_q <= cfg_data_i[cpi_pkg::CountW-1:0];
          cpi_pkg::CfgLinearMode: linear_q      <= cfg_data_i[0];
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (accept && func_i == cpi_pkg::FuncQuery) begin
            n_q     <= n_sat;
            idx_q   <= '0;
            match_q <= 1'b0;
            seg_q   <= 1'b0;
            if (n_sat == '0) begin
              mapped_q <= query_value_i;
              how_q    <= cpi_pkg::HowPass;
              strobe_q <= 1'b1;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (!match_q && hit_eq) begin
            match_q <= 1'b1;
          end
          if (idx_q != '0 && !seg_q && seg_hit) begin
            seg_q <= 1'b1;
          end
          idx_q <= idx_q + CW'(1);
          if (last_pt) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          state_q  <= StIdle;
          strobe_q <= 1'b1;
          if (match_q) begin
            mapped_q <= match_out_q;
            how_q    <= cpi_pkg::HowExact;
          end else if (linear_q) begin
            mapped_q <= q_q;
            how_q    <= cpi_pkg::HowPass;
          end else if (q_q < first_in_q) begin
            mapped_q <= first_out_q;
            how_q    <= cpi_pkg::HowClampLo;
          end else if (q_q > prev_in_q) begin
            mapped_q <= prev_out_q;
            how_q    <= cpi_pkg::HowClampHi;
          end else if (seg_q) begin
            if (rin_q == lin_q) begin
              mapped_q <= lout_q;
              how_q    <= cpi_pkg::HowInterp;
            end else begin
              state_q  <= StPrep;
              strobe_q <= 1'b0;
            end
          end else begin
            mapped_q <= q_q;
            how_q    <= cpi_pkg::HowPass;
          end
        end
        StPrep:  state_q <= StMul;
        StMul:   state_q <= StDivGo;
        StDivGo: state_q <= StDivWait;
        StDivWait: begin
          if (div_done) begin
            state_q  <= StIdle;
            strobe_q <= 1'b1;
            how_q    <= cpi_pkg::HowInterp;
            mapped_q <= neg_q ? (lout_q - $signed(quo)) : (lout_q + $signed(quo));
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_q <= query_value_i;
    end
    if (state_q == StScan) begin
      prev_in_q  <= rd_in;
      prev_out_q <= rd_out;
      if (idx_q == '0) begin
        first_in_q  <= rd_in;
        first_out_q <= rd_out;
      end
      if (!match_q && hit_eq) begin
        match_out_q <= rd_out;
      end
      if (idx_q != '0 && !seg_q && seg_hit) begin
        lin_q  <= prev_in_q;
        lout_q <= prev_out_q;
        rin_q  <= rd_in;
        rout_q <= rd_out;
      end
    end
    if (state_q == StPrep) begin
      span_q <= W'(rin_q - lin_q);
      run_q  <= W'(q_q - lin_q);
      neg_q  <= rise[W];
      mag_q  <= rise[W] ? rise_neg[W-1:0] : rise[W-1:0];
    end
    if (state_q == StMul) begin
      prod_q <= mag_q * run_q;
    end
  end

  // divider request
  always_comb begin
    div_req.start    = (state_q == StDivGo);
    div_req.dividend = prod_q;
    div_req.divisor  = span_q;
  end

  cpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign strobe_o       = strobe_q;
  assign mapped_value_o = mapped_q;
  assign how_found_o    = how_q;

endmodule

`default_nettype wire

/* src/cpi_checker.sv */
`default_nettype none

// Port-level checks on the command and result timing.
module cpi_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic strobe_o
);

  // busy only rises right after a beat was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");

  // a result is never shown while a query is still in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result strobe while busy");

  // every busy period ends with exactly its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o)
    else $error("busy ended without a result");

  // a result follows either a finished query or a direct lookup beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ($past(busy) || $past(start)))
    else $error("result without a query");

endmodule

bind curve_point_interpolator_top cpi_checker u_cpi_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o)
);

`default_nettype wire
